FILE: sv/assert_macros.svh
// Assertion helpers for the dictionary RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked at every rising edge of clk while rst is low.
`define QPD_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked at every rising edge of clk, reset included.
`define QPD_ASSERT_ALWAYS(name, prop, msg) \
  name: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: sv/qpd_pkg.sv
package qpd_pkg;

  localparam logic [1:0] OP_INSERT = 2'd0;
  localparam logic [1:0] OP_SEARCH = 2'd1;
  localparam logic [1:0] OP_DELETE = 2'd2;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_MISSING = 2'd1;
  localparam logic [1:0] ST_FULL    = 2'd2;

  // A key holds at most this many characters.
  localparam int KEY_BYTES = 8;

  // Byte sum of a 64-bit key is at most 8 * 255, which fits in 11 bits.
  localparam int SUM_W = 11;
  // Shift of the reciprocal used to reduce the byte sum by the table size.
  localparam int RECIP_SHIFT = 20;

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_HASH  = 4'b0010,
    S_MOD   = 4'b0100,
    S_PROBE = 4'b1000
  } state_t;

  typedef struct packed {
    logic load;
    logic step;
  } probe_ctl_t;

endpackage

FILE: sv/quadratic_probe_hash_dictionary.sv
// Dictionary of TABLE_SIZE slots with quadratic probing. An item is taken when
// start is high and busy is low; its single result appears on status,
// found_value and slot_index for exactly one cycle with done high, and cannot
// be held off. A zero key or an unknown operation answers in the cycle after
// the item is taken. Any other item hashes the key in S_HASH and S_MOD, then
// probes one slot per cycle (one read of the key and value memories each),
// and answers in the cycle after the last probe. The next item may be taken
// in the cycle the result shows. The table is empty right after reset with
// no clearing pass.
module quadratic_probe_hash_dictionary #(
  parameter int TABLE_SIZE = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [1:0]  operation,
  input  logic [63:0] key_word,
  input  logic [63:0] value_word,
  output logic        busy,
  output logic        done,
  output logic [1:0]  status,
  output logic [63:0] found_value,
  output logic [3:0]  slot_index
);

  import qpd_pkg::*;

  `include "assert_macros.svh"

  localparam int AW = $clog2(TABLE_SIZE);
  localparam int ProdW = SUM_W + RECIP_SHIFT;
  localparam logic [RECIP_SHIFT-1:0] Recip =
    RECIP_SHIFT'(((1 << RECIP_SHIFT) + TABLE_SIZE - 1) / TABLE_SIZE);

  state_t          state;
  logic [1:0]      op;
  logic [63:0]     key_reg;
  logic [63:0]     value_reg;
  logic [63:0]     key_norm;
  logic            bad_item;
  logic            accept;
  logic [SUM_W-1:0] sum;
  logic [SUM_W-1:0] sum_reg;
  logic [SUM_W-1:0] quot;
  logic [ProdW-1:0] prod;
  logic [SUM_W-1:0] rem;
  logic [AW-1:0]   home;
  probe_ctl_t      pctl;
  logic [AW-1:0]   addr;
  logic [AW-1:0]   raddr;
  logic            last;
  logic [TABLE_SIZE-1:0] valid;
  logic [63:0]     key_rd;
  logic [63:0]     val_rd;
  logic            used;
  logic            hit;
  logic            we;

  // The key ends at its first zero byte or after KEY_BYTES bytes.
  always_comb begin
    logic keep;
    keep     = 1'b1;
    key_norm = '0;
    for (int j = 0; j < 8; j++) begin
      if (j >= KEY_BYTES || key_word[8*j +: 8] == 8'd0) begin
        keep = 1'b0;
      end
      if (keep) begin
        key_norm[8*j +: 8] = key_word[8*j +: 8];
      end
    end
  end

  assign busy     = (state != S_IDLE);
  assign accept   = start && !busy;
  assign bad_item = (key_norm == 64'd0) ||
                    !(operation == OP_INSERT || operation == OP_SEARCH ||
                      operation == OP_DELETE);

  always_comb begin
    sum = '0;
    for (int j = 0; j < 8; j++) begin
      sum = sum + SUM_W'(key_reg[8*j +: 8]);
    end
  end

  // Quotient by a rounded-up reciprocal is exact for sums below 2^SUM_W.
  assign prod = ProdW'(sum) * ProdW'(Recip);
  assign rem  = sum_reg - quot * SUM_W'(TABLE_SIZE);
  assign home = AW'(rem);

  // An empty slot is one whose valid bit is clear; stored keys are nonzero.
  assign used = valid[addr];
  assign hit  = (op == OP_INSERT) ? !used : (used && key_rd == key_reg);
  assign we   = (state == S_PROBE) && hit && (op == OP_INSERT);

  assign pctl.load = (state == S_MOD);
  assign pctl.step = (state == S_PROBE) && !hit && !last;

  qpd_probe #(.TABLE_SIZE(TABLE_SIZE)) u_probe (
    .clk       (clk),
    .ctl       (pctl),
    .home      (home),
    .addr      (addr),
    .addr_next (raddr),
    .last      (last)
  );

  qpd_ram #(.WIDTH(64), .DEPTH(TABLE_SIZE)) u_key_ram (
    .clk   (clk),
    .we    (we),
    .waddr (addr),
    .wdata (key_reg),
    .raddr (raddr),
    .rdata (key_rd)
  );

  qpd_ram #(.WIDTH(64), .DEPTH(TABLE_SIZE)) u_value_ram (
    .clk   (clk),
    .we    (we),
    .waddr (addr),
    .wdata (value_reg),
    .raddr (raddr),
    .rdata (val_rd)
  );

  // Delete only drops the valid bit; an invalid slot reads as empty.
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else if (state == S_PROBE && hit) begin
      if (op == OP_INSERT) begin
        valid[addr] <= 1'b1;
      end else if (op == OP_DELETE) begin
        valid[addr] <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      op        <= operation;
      key_reg   <= key_norm;
      value_reg <= value_word;
    end
    if (state == S_HASH) begin
      sum_reg <= sum;
      quot    <= prod[ProdW-1 -: SUM_W];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        S_IDLE: begin
          if (accept) begin
            if (bad_item) begin
              done        <= 1'b1;
              status      <= ST_MISSING;
              found_value <= '0;
              slot_index  <= '0;
            end else begin
              state <= S_HASH;
            end
          end
        end
        S_HASH: begin
          state <= S_MOD;
        end
        S_MOD: begin
          state <= S_PROBE;
        end
        S_PROBE: begin
          if (hit) begin
            state       <= S_IDLE;
            done        <= 1'b1;
            status      <= ST_OK;
            slot_index  <= 4'(addr);
            found_value <= (op == OP_SEARCH) ? val_rd : 64'd0;
          end else if (last) begin
            state       <= S_IDLE;
            done        <= 1'b1;
            status      <= (op == OP_INSERT) ? ST_FULL : ST_MISSING;
            slot_index  <= '0;
            found_value <= '0;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  `QPD_ASSERT(a_done_when_idle, done |-> !busy, "result shown while an item is in work")
  `QPD_ASSERT(a_fail_zero, done && status != ST_OK |-> found_value == 64'd0 && slot_index == 4'd0, "failed item carries nonzero payload")
  `QPD_ASSERT(a_good_item_works, accept && !bad_item |=> busy && !done, "valid item did not start a lookup")
  `QPD_ASSERT_ALWAYS(a_reset_idle, rst |=> !busy && !done, "block not idle after reset")

endmodule

FILE: sv/qpd_ram.sv
module qpd_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: sv/qpd_probe.sv
module qpd_probe #(
  parameter int TABLE_SIZE = 16
) (
  input  logic                          clk,
  input  qpd_pkg::probe_ctl_t           ctl,
  input  logic [$clog2(TABLE_SIZE)-1:0] home,
  output logic [$clog2(TABLE_SIZE)-1:0] addr,
  output logic [$clog2(TABLE_SIZE)-1:0] addr_next,
  output logic                          last
);

  import qpd_pkg::*;

  localparam int AW = $clog2(TABLE_SIZE);

  // The offset i*i grows by 2i+1 from one probe to the next; both the slot
  // and that increment are kept reduced modulo the table size.
  logic [AW-1:0] inc;
  logic [AW-1:0] inc_next;
  logic [AW-1:0] count;
  logic [AW:0]   addr_sum;
  logic [AW:0]   inc_sum;

  assign addr_sum = {1'b0, addr} + {1'b0, inc};
  assign inc_sum  = {1'b0, inc} + (AW+1)'(2);
  assign last     = (count == AW'(TABLE_SIZE - 1));

  always_comb begin
    if (ctl.load) begin
      addr_next = home;
      inc_next  = AW'(1 % TABLE_SIZE);
    end else if (ctl.step) begin
      if (addr_sum >= (AW+1)'(TABLE_SIZE)) begin
        addr_next = AW'(addr_sum - (AW+1)'(TABLE_SIZE));
      end else begin
        addr_next = AW'(addr_sum);
      end
      if (inc_sum >= (AW+1)'(TABLE_SIZE)) begin
        inc_next = AW'(inc_sum - (AW+1)'(TABLE_SIZE));
      end else begin
        inc_next = AW'(inc_sum);
      end
    end else begin
      addr_next = addr;
      inc_next  = inc;
    end
  end

  always_ff @(posedge clk) begin
    addr <= addr_next;
    inc  <= inc_next;
    if (ctl.load) begin
      count <= '0;
    end else if (ctl.step) begin
      count <= count + AW'(1);
    end
  end

endmodule
